// ----- rtl/yiq2rgb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq2rgb_pkg
// Shared widths, register indexes, matrix coefficients and stage types for
// the YIQ to RGB converter.
// ----------------------------------------------------------------------------
package yiq2rgb_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int CHROMA_W     = 16;
    localparam int BLACK_W      = 16;
    localparam int LGAIN_W      = 24;
    localparam int CGAIN_W      = 16;

    // Configuration port
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_75    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_GAIN = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MONO        = CFG_IDX_W'(4);

    // Register reset values
    localparam logic [BLACK_W-1:0] RST_BLACK_LEVEL = BLACK_W'(0);
    localparam logic [LGAIN_W-1:0] RST_LUMA_GAIN   = LGAIN_W'(65536);
    localparam logic [CGAIN_W-1:0] RST_CHROMA_GAIN = CGAIN_W'(4096);

    // Datapath widths
    localparam int D_W     = ((SAMPLE_WIDTH > BLACK_W) ? SAMPLE_WIDTH : BLACK_W) + 1;
    localparam int P_W     = D_W + LGAIN_W + 1;      // luma product, Q.16
    localparam int P5_W    = P_W + 3;                // room for times five
    localparam int Y_FRAC  = 14;
    localparam int Y_W     = SAMPLE_WIDTH + Y_FRAC;  // clamped luma, Q.14
    localparam int IV_W    = CHROMA_W + CGAIN_W;     // scaled chroma, Q.12
    localparam int COEF_W  = 16;
    localparam int PROD_W  = IV_W + COEF_W;          // matrix term, Q.26
    localparam int Y_SHIFT = 12;                     // Q.14 to Q.26
    localparam int CH_FRAC = Y_FRAC + Y_SHIFT;
    localparam int SUM_W   = ((Y_W + Y_SHIFT > PROD_W) ? Y_W + Y_SHIFT : PROD_W) + 2;

    localparam logic [Y_W-1:0] Y_MAX = {{SAMPLE_WIDTH{1'b1}}, {Y_FRAC{1'b0}}};

    // Matrix coefficients, Q2.14
    localparam logic signed [PROD_W-1:0] C_RI = PROD_W'(15663);
    localparam logic signed [PROD_W-1:0] C_RQ = PROD_W'(10174);
    localparam logic signed [PROD_W-1:0] C_GI = PROD_W'(4456);
    localparam logic signed [PROD_W-1:0] C_GQ = PROD_W'(10600);
    localparam logic signed [PROD_W-1:0] C_BI = PROD_W'(18137);
    localparam logic signed [PROD_W-1:0] C_BQ = PROD_W'(27918);

    // Register file contents
    typedef struct packed {
        logic [BLACK_W-1:0] black_level;
        logic [LGAIN_W-1:0] luma_gain;
        logic               white_75;
        logic [CGAIN_W-1:0] chroma_gain;
        logic               mono;
    } t_cfg;

    // Scaled sample between gain and matrix sections
    typedef struct packed {
        logic signed [P_W-1:0]  p;
        logic signed [IV_W-1:0] iv;
        logic signed [IV_W-1:0] qv;
        logic                   last;
    } t_scaled;

endpackage

// ----- rtl/yiq2rgb_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq2rgb_cfg
// Configuration registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module yiq2rgb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [yiq2rgb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [yiq2rgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output yiq2rgb_pkg::t_cfg                 o_cfg
);

    yiq2rgb_pkg::t_cfg r_cfg;

    // Decode the index and store the write; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black_level <= yiq2rgb_pkg::RST_BLACK_LEVEL;
            r_cfg.luma_gain   <= yiq2rgb_pkg::RST_LUMA_GAIN;
            r_cfg.white_75    <= 1'b0;
            r_cfg.chroma_gain <= yiq2rgb_pkg::RST_CHROMA_GAIN;
            r_cfg.mono        <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                yiq2rgb_pkg::CFG_BLACK_LEVEL: begin
                    r_cfg.black_level <= i_cfg_data[yiq2rgb_pkg::BLACK_W-1:0];
                end
                yiq2rgb_pkg::CFG_LUMA_GAIN: begin
                    r_cfg.luma_gain <= i_cfg_data[yiq2rgb_pkg::LGAIN_W-1:0];
                end
                yiq2rgb_pkg::CFG_WHITE_75: begin
                    r_cfg.white_75 <= i_cfg_data[0];
                end
                yiq2rgb_pkg::CFG_CHROMA_GAIN: begin
                    r_cfg.chroma_gain <= i_cfg_data[yiq2rgb_pkg::CGAIN_W-1:0];
                end
                yiq2rgb_pkg::CFG_MONO: begin
                    r_cfg.mono <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/yiq2rgb_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq2rgb_scale
// Stages 1-2: black level subtract and chroma gating, then luma and chroma
// gain multiplies.
// ----------------------------------------------------------------------------
module yiq2rgb_scale (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  yiq2rgb_pkg::t_cfg                       i_cfg,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0]    i_luma,
    input  logic signed [yiq2rgb_pkg::CHROMA_W-1:0] i_in_phase,
    input  logic signed [yiq2rgb_pkg::CHROMA_W-1:0] i_quadrature,
    input  logic                                    i_last_in_line,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output yiq2rgb_pkg::t_scaled                    o_data
);

    localparam int D_W  = yiq2rgb_pkg::D_W;
    localparam int P_W  = yiq2rgb_pkg::P_W;
    localparam int IV_W = yiq2rgb_pkg::IV_W;
    localparam int C_W  = yiq2rgb_pkg::CHROMA_W;

    logic w_rdy1;
    logic w_rdy2;

    // Stage 1 registers
    logic                  r_v1;
    logic signed [D_W-1:0] r_d;
    logic signed [C_W-1:0] r_i;
    logic signed [C_W-1:0] r_q;
    logic                  r_last1;

    // Stage 2 registers
    logic                   r_v2;
    logic signed [P_W-1:0]  r_p;
    logic signed [IV_W-1:0] r_iv;
    logic signed [IV_W-1:0] r_qv;
    logic                   r_last2;

    logic signed [D_W-1:0]  n_d;
    logic signed [C_W-1:0]  n_i;
    logic signed [C_W-1:0]  n_q;
    logic signed [P_W-1:0]  n_p;
    logic signed [IV_W-1:0] n_iv;
    logic signed [IV_W-1:0] n_qv;

    logic signed [P_W-1:0]  w_d_ext;
    logic signed [P_W-1:0]  w_lg_ext;
    logic signed [IV_W-1:0] w_i_ext;
    logic signed [IV_W-1:0] w_q_ext;
    logic signed [IV_W-1:0] w_cg_ext;

    // A stage advances when it is empty or the next one takes its item
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Subtract black level; gate chroma in monochrome mode
    always_comb begin
        n_d = $signed(D_W'(i_luma)) - $signed(D_W'(i_cfg.black_level));
        n_i = i_cfg.mono ? '0 : i_in_phase;
        n_q = i_cfg.mono ? '0 : i_quadrature;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_d     <= n_d;
            r_i     <= n_i;
            r_q     <= n_q;
            r_last1 <= i_last_in_line;
        end
    end

    // Gain multiplies, operands extended to the product width
    always_comb begin
        w_d_ext  = P_W'(r_d);
        w_lg_ext = $signed(P_W'(i_cfg.luma_gain));
        w_i_ext  = IV_W'(r_i);
        w_q_ext  = IV_W'(r_q);
        w_cg_ext = $signed(IV_W'(i_cfg.chroma_gain));
        n_p      = w_d_ext * w_lg_ext;
        n_iv     = w_i_ext * w_cg_ext;
        n_qv     = w_q_ext * w_cg_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_p     <= n_p;
            r_iv    <= n_iv;
            r_qv    <= n_qv;
            r_last2 <= r_last1;
        end
    end

    assign o_valid      = r_v2;
    assign o_data.p     = r_p;
    assign o_data.iv    = r_iv;
    assign o_data.qv    = r_qv;
    assign o_data.last  = r_last2;

`ifndef SYNTH
    // A blocked stage 2 item holds until the matrix section takes it
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_ready |=> r_v2 && $stable(r_p) && $stable(r_iv) && $stable(r_qv))
        else $error("stage 2 item changed while stalled");

    // Stage 1 cannot be overwritten while stage 2 is blocked and full
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && !i_ready |=> r_v1 && $stable(r_d) && $stable(r_i))
        else $error("stage 1 item changed while stalled");
`endif

endmodule

// ----- rtl/yiq2rgb_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq2rgb_matrix
// Stages 3-5: luma scaling and clamp with matrix products, channel sums,
// then channel clamp into the output register.
// ----------------------------------------------------------------------------
module yiq2rgb_matrix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  yiq2rgb_pkg::t_cfg                    i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  yiq2rgb_pkg::t_scaled                 i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0] o_red,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0] o_green,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0] o_blue,
    output logic                                 o_line_end
);

    localparam int SW     = yiq2rgb_pkg::SAMPLE_WIDTH;
    localparam int P_W    = yiq2rgb_pkg::P_W;
    localparam int P5_W   = yiq2rgb_pkg::P5_W;
    localparam int Y_W    = yiq2rgb_pkg::Y_W;
    localparam int PROD_W = yiq2rgb_pkg::PROD_W;
    localparam int SUM_W  = yiq2rgb_pkg::SUM_W;
    localparam int FRAC   = yiq2rgb_pkg::CH_FRAC;

    // Negative sums give zero; integer part saturates at full scale
    function automatic logic [SW-1:0] to_channel(input logic signed [SUM_W-1:0] s);
        logic [SW-1:0] v;
        if (s[SUM_W-1]) begin
            v = '0;
        end else if (|s[SUM_W-1:FRAC+SW]) begin
            v = '1;
        end else begin
            v = s[FRAC+SW-1:FRAC];
        end
        return v;
    endfunction

    logic w_rdy3;
    logic w_rdy4;
    logic w_rdy5;

    // Stage 3 registers
    logic                     r_v3;
    logic [Y_W-1:0]           r_y;
    logic signed [PROD_W-1:0] r_ri;
    logic signed [PROD_W-1:0] r_rq;
    logic signed [PROD_W-1:0] r_gi;
    logic signed [PROD_W-1:0] r_gq;
    logic signed [PROD_W-1:0] r_bi;
    logic signed [PROD_W-1:0] r_bq;
    logic                     r_last3;

    // Stage 4 registers
    logic                    r_v4;
    logic signed [SUM_W-1:0] r_sum_r;
    logic signed [SUM_W-1:0] r_sum_g;
    logic signed [SUM_W-1:0] r_sum_b;
    logic                    r_last4;

    // Stage 5 (output) registers
    logic          r_v5;
    logic [SW-1:0] r_red;
    logic [SW-1:0] r_green;
    logic [SW-1:0] r_blue;
    logic          r_last5;

    logic signed [P5_W-1:0]   w_p5;
    logic signed [P5_W-1:0]   w_y_full;
    logic                     w_p_pos;
    logic [Y_W-1:0]           n_y;
    logic signed [PROD_W-1:0] w_iv_e;
    logic signed [PROD_W-1:0] w_qv_e;
    logic signed [SUM_W-1:0]  w_y26;
    logic signed [SUM_W-1:0]  n_sum_r;
    logic signed [SUM_W-1:0]  n_sum_g;
    logic signed [SUM_W-1:0]  n_sum_b;

    // Ready chain: a stage advances when empty or drained downstream
    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;

    // Luma: Q.16 product to Q.14, times 5/4 in 75% white mode, clamped
    always_comb begin
        w_p5     = P5_W'(i_data.p);
        w_p_pos  = !i_data.p[P_W-1] && (i_data.p != '0);
        w_y_full = i_cfg.white_75 ? ((w_p5 + (w_p5 <<< 2)) >>> 4) : (w_p5 >>> 2);
        if (!w_p_pos) begin
            n_y = '0;
        end else if ($unsigned(w_y_full) > P5_W'(yiq2rgb_pkg::Y_MAX)) begin
            n_y = yiq2rgb_pkg::Y_MAX;
        end else begin
            n_y = Y_W'(w_y_full);
        end
        w_iv_e = PROD_W'(i_data.iv);
        w_qv_e = PROD_W'(i_data.qv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= i_valid;
        end
    end

    // Matrix products, one per coefficient
    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_y     <= n_y;
            r_ri    <= w_iv_e * yiq2rgb_pkg::C_RI;
            r_rq    <= w_qv_e * yiq2rgb_pkg::C_RQ;
            r_gi    <= w_iv_e * yiq2rgb_pkg::C_GI;
            r_gq    <= w_qv_e * yiq2rgb_pkg::C_GQ;
            r_bi    <= w_iv_e * yiq2rgb_pkg::C_BI;
            r_bq    <= w_qv_e * yiq2rgb_pkg::C_BQ;
            r_last3 <= i_data.last;
        end
    end

    // Channel sums in Q.26
    always_comb begin
        w_y26   = $signed(SUM_W'({r_y, {yiq2rgb_pkg::Y_SHIFT{1'b0}}}));
        n_sum_r = w_y26 + SUM_W'(r_ri) + SUM_W'(r_rq);
        n_sum_g = w_y26 - SUM_W'(r_gi) - SUM_W'(r_gq);
        n_sum_b = w_y26 - SUM_W'(r_bi) + SUM_W'(r_bq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
            r_last4 <= r_last3;
        end
    end

    // Clamp into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            r_red   <= to_channel(r_sum_r);
            r_green <= to_channel(r_sum_g);
            r_blue  <= to_channel(r_sum_b);
            r_last5 <= r_last4;
        end
    end

    assign o_valid    = r_v5;
    assign o_red      = r_red;
    assign o_green    = r_green;
    assign o_blue     = r_blue;
    assign o_line_end = r_last5;

`ifndef SYNTH
    // Clamped luma never exceeds full scale in Q.14
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_y <= yiq2rgb_pkg::Y_MAX)
        else $error("luma above full scale");

    // Sums hold while the output register is blocked
    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !w_rdy5 |=> r_v4 && $stable(r_sum_r) && $stable(r_sum_g)
            && $stable(r_sum_b) && $stable(r_last4))
        else $error("stage 4 item changed while stalled");
`endif

endmodule

// ----- rtl/yiq_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq_to_rgb_converter
// YIQ sample to 16-bit RGB: black level and gain on luma, gain or mono gate
// on chroma, fixed matrix, per-channel clamp.
//
// Channel    Handshake                   Payload
// input      i_in_valid / o_in_ready     i_luma, i_in_phase, i_quadrature,
//                                        i_last_in_line
// output     o_out_valid / i_out_ready   o_red, o_green, o_blue, o_line_end
// config     i_cfg_wr_en (no wait)       i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled; five register
// stages lie between the input port and the output register.
// Each stage advances on its own when empty, so bubbles close up under stall
// and an item is never dropped or repeated.
// Synchronous active-low reset clears the stage valid bits and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module yiq_to_rgb_converter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [yiq2rgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [yiq2rgb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0]    i_luma,
    input  logic signed [yiq2rgb_pkg::CHROMA_W-1:0] i_in_phase,
    input  logic signed [yiq2rgb_pkg::CHROMA_W-1:0] i_quadrature,
    input  logic                                    i_last_in_line,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0]    o_red,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0]    o_green,
    output logic [yiq2rgb_pkg::SAMPLE_WIDTH-1:0]    o_blue,
    output logic                                    o_line_end
);

    yiq2rgb_pkg::t_cfg    w_cfg;
    yiq2rgb_pkg::t_scaled w_scaled;
    logic                 w_scaled_valid;
    logic                 w_scaled_ready;

    // Register file
    yiq2rgb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Gain section, stages 1-2
    yiq2rgb_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_luma         (i_luma),
        .i_in_phase     (i_in_phase),
        .i_quadrature   (i_quadrature),
        .i_last_in_line (i_last_in_line),
        .o_valid        (w_scaled_valid),
        .i_ready        (w_scaled_ready),
        .o_data         (w_scaled)
    );

    // Matrix section, stages 3-5
    yiq2rgb_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_scaled_valid),
        .o_ready    (w_scaled_ready),
        .i_data     (w_scaled),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_line_end (o_line_end)
    );

endmodule

// ----- tb/yiq_to_rgb_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq_to_rgb_converter_tb
// Self-checking bench for the YIQ to RGB converter. A directed table of
// samples runs first at the register defaults. Random samples follow under a
// series of register settings that include the extremes, zero gains and
// monochrome mode. Every output transfer is checked field by field against
// a table value or an in-bench fixed-point model of the conversion. Both handshakes idle at
// random, and one long output hold-off backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module yiq_to_rgb_converter_tb;

    localparam int SAMPLE_WIDTH = yiq2rgb_pkg::SAMPLE_WIDTH;
    localparam int CHROMA_W     = yiq2rgb_pkg::CHROMA_W;
    localparam int BLACK_W      = yiq2rgb_pkg::BLACK_W;
    localparam int LGAIN_W      = yiq2rgb_pkg::LGAIN_W;
    localparam int CGAIN_W      = yiq2rgb_pkg::CGAIN_W;
    localparam int CFG_IDX_W    = yiq2rgb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = yiq2rgb_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = yiq2rgb_pkg::CFG_BLACK_LEVEL;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN   = yiq2rgb_pkg::CFG_LUMA_GAIN;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_75    = yiq2rgb_pkg::CFG_WHITE_75;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_GAIN = yiq2rgb_pkg::CFG_CHROMA_GAIN;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO        = yiq2rgb_pkg::CFG_MONO;

    localparam logic [BLACK_W-1:0] RST_BLACK_LEVEL = yiq2rgb_pkg::RST_BLACK_LEVEL;
    localparam logic [LGAIN_W-1:0] RST_LUMA_GAIN   = yiq2rgb_pkg::RST_LUMA_GAIN;
    localparam logic [CGAIN_W-1:0] RST_CHROMA_GAIN = yiq2rgb_pkg::RST_CHROMA_GAIN;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_PROBES        = 14;

    // Matrix coefficients, Q2.14
    localparam longint K_RI = 15663;
    localparam longint K_RQ = 10174;
    localparam longint K_GI = 4456;
    localparam longint K_GQ = 10600;
    localparam longint K_BI = 18137;
    localparam longint K_BQ = 27918;

    localparam longint CHAN_MAX  = (longint'(1) <<< SAMPLE_WIDTH) - 1;
    localparam longint LUMA_CEIL = CHAN_MAX <<< 14;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] red;
        logic [SAMPLE_WIDTH-1:0] green;
        logic [SAMPLE_WIDTH-1:0] blue;
        logic                    line_end;
    } t_rgb_px;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0]    luma;
        logic signed [CHROMA_W-1:0] iph;
        logic signed [CHROMA_W-1:0] quad;
        logic                       eol;
        logic                       typed;
        t_rgb_px                    px;
    } t_probe_row;

    // Directed samples at the register defaults; gray rows pass luma through
    localparam t_probe_row PROBES [N_PROBES] = '{
        '{16'd0,     16'sd0,      16'sd0,      1'b0, 1'b1,
          '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{16'd65535, 16'sd0,      16'sd0,      1'b1, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b1}},
        '{16'd32768, 16'sd0,      16'sd0,      1'b0, 1'b1,
          '{16'd32768, 16'd32768, 16'd32768, 1'b0}},
        '{16'd1,     16'sd0,      16'sd0,      1'b0, 1'b1,
          '{16'd1, 16'd1, 16'd1, 1'b0}},
        '{16'd32767, 16'sd0,      16'sd0,      1'b1, 1'b1,
          '{16'd32767, 16'd32767, 16'd32767, 1'b1}},
        '{16'd0,     16'sh8000,   16'sh8000,   1'b0, 1'b1,
          '{16'd0, 16'd30112, 16'd0, 1'b0}},
        '{16'd65535, 16'sh7FFF,   16'sh7FFF,   1'b1, 1'b0, '0},
        '{16'd65535, 16'sh8000,   16'sh7FFF,   1'b0, 1'b0, '0},
        '{16'd0,     16'sh7FFF,   16'sh8000,   1'b0, 1'b0, '0},
        '{16'd16384, 16'sd1000,   -16'sd1000,  1'b0, 1'b0, '0},
        '{16'd21845, -16'sd1,     -16'sd1,     1'b1, 1'b0, '0},
        '{16'hAAAA,  16'sh5555,   16'shAAAA,   1'b0, 1'b0, '0},
        '{16'd40000, 16'sd0,      16'sh7FFF,   1'b0, 1'b0, '0},
        '{16'd40000, 16'sh8000,   16'sd0,      1'b1, 1'b0, '0}
    };

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic [SAMPLE_WIDTH-1:0]    luma           = '0;
    logic signed [CHROMA_W-1:0] in_phase       = '0;
    logic signed [CHROMA_W-1:0] quadrature     = '0;
    logic                       last_in_line   = 1'b0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic [SAMPLE_WIDTH-1:0]    red;
    logic [SAMPLE_WIDTH-1:0]    green;
    logic [SAMPLE_WIDTH-1:0]    blue;
    logic                       line_end;

    // Shadow of the register file and pixels still owed by the block
    yiq2rgb_pkg::t_cfg regs = '{black_level: RST_BLACK_LEVEL, luma_gain: RST_LUMA_GAIN,
                                white_75: 1'b0, chroma_gain: RST_CHROMA_GAIN,
                                mono: 1'b0};
    t_rgb_px rgb_pending [$];

    int send_idle  = 0;
    int recv_stall = 0;
    int errors     = 0;
    int quiet      = 0;
    int hold_reqs  = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    yiq_to_rgb_converter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_luma         (luma),
        .i_in_phase     (in_phase),
        .i_quadrature   (quadrature),
        .i_last_in_line (last_in_line),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_red          (red),
        .o_green        (green),
        .o_blue         (blue),
        .o_line_end     (line_end)
    );

    always #5 clk = ~clk;

    // Q.26 channel sum to a clamped 16-bit level
    function automatic logic [SAMPLE_WIDTH-1:0] saturate_channel(input longint s);
        longint v;
        if (s < 0)
            return '0;
        v = s >>> 26;
        if (v > CHAN_MAX)
            v = CHAN_MAX;
        return SAMPLE_WIDTH'(v);
    endfunction

    // Expected pixel for one sample under the current register shadow
    function automatic t_rgb_px predict_rgb(input logic [SAMPLE_WIDTH-1:0] y_in,
                                            input logic signed [CHROMA_W-1:0] i_in,
                                            input logic signed [CHROMA_W-1:0] q_in,
                                            input logic eol);
        longint  diff;
        longint  prod;
        longint  y14;
        longint  iv;
        longint  qv;
        longint  y26;
        t_rgb_px px;
        diff = longint'(y_in) - longint'(regs.black_level);
        prod = diff * longint'(regs.luma_gain);
        if (prod <= 0)
            y14 = 0;
        else if (regs.white_75)
            y14 = (prod * 5) >>> 4;
        else
            y14 = prod >>> 2;
        if (y14 > LUMA_CEIL)
            y14 = LUMA_CEIL;
        iv = 0;
        qv = 0;
        if (!regs.mono) begin
            iv = longint'(i_in) * longint'(regs.chroma_gain);
            qv = longint'(q_in) * longint'(regs.chroma_gain);
        end
        y26         = y14 <<< 12;
        px.red      = saturate_channel(y26 + K_RI * iv + K_RQ * qv);
        px.green    = saturate_channel(y26 - K_GI * iv - K_GQ * qv);
        px.blue     = saturate_channel(y26 - K_BI * iv + K_BQ * qv);
        px.line_end = eol;
        return px;
    endfunction

    // Chroma mix: rails, zero, small swings around zero, full range
    function automatic logic signed [CHROMA_W-1:0] random_chroma();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return CHROMA_W'($urandom_range(0, 511)) - CHROMA_W'(256);
            default: return CHROMA_W'($urandom);
        endcase
    endfunction

    // Offer one sample, hold it until the transfer, then log its pixel
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] y_in,
                               input logic signed [CHROMA_W-1:0] i_in,
                               input logic signed [CHROMA_W-1:0] q_in,
                               input logic eol,
                               input logic typed,
                               input t_rgb_px typed_px);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        luma         <= y_in;
        in_phase     <= i_in;
        quadrature   <= q_in;
        last_in_line <= eol;
        do
            @(posedge clk);
        while (!in_ready);
        rgb_pending.push_back(typed ? typed_px : predict_rgb(y_in, i_in, q_in, eol));
    endtask

    // Drop valid, wait out every owed pixel, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (rgb_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_BLACK_LEVEL: regs.black_level = data[BLACK_W-1:0];
            CFG_LUMA_GAIN:   regs.luma_gain   = data[LGAIN_W-1:0];
            CFG_WHITE_75:    regs.white_75    = data[0];
            CFG_CHROMA_GAIN: regs.chroma_gain = data[CGAIN_W-1:0];
            CFG_MONO:        regs.mono        = data[0];
            default: ;
        endcase
    endtask

    // Write all registers, with junk above every field narrower than the data word, plus one undecoded index
    task automatic load_settings(input logic [BLACK_W-1:0] bl,
                                 input logic [LGAIN_W-1:0] lg,
                                 input logic w75,
                                 input logic [CGAIN_W-1:0] cg,
                                 input logic mn);
        write_reg(CFG_BLACK_LEVEL, {8'($urandom), bl});
        write_reg(CFG_LUMA_GAIN, lg);
        write_reg(CFG_WHITE_75, {23'($urandom), w75});
        write_reg(CFG_CHROMA_GAIN, {8'($urandom), cg});
        write_reg(CFG_MONO, {23'($urandom), mn});
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                  CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_taken != hold_reqs) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = hold_reqs;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Check each output transfer against the oldest owed pixel
    always @(posedge clk) begin
        t_rgb_px want;
        if (rst_n && out_valid && out_ready) begin
            if (rgb_pending.size() == 0) begin
                $error("unexpected output transfer: red %0d green %0d blue %0d line_end %0b",
                       red, green, blue, line_end);
                errors++;
            end else begin
                want = rgb_pending.pop_front();
                if (red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    errors++;
                end
                if (green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    errors++;
                end
                if (blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    errors++;
                end
                if (line_end !== want.line_end) begin
                    $error("line_end: expected %0b, got %0b", want.line_end, line_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("yiq_to_rgb_converter_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [BLACK_W-1:0]         bl;
        logic [LGAIN_W-1:0]         lg;
        logic                       w75;
        logic [CGAIN_W-1:0]         cg;
        logic                       mn;
        logic [SAMPLE_WIDTH-1:0]    y_in;
        logic signed [CHROMA_W-1:0] i_in;
        logic signed [CHROMA_W-1:0] q_in;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset defaults
        for (int r = 0; r < N_PROBES; r++)
            send_sample(PROBES[r].luma, PROBES[r].iph, PROBES[r].quad, PROBES[r].eol,
                        PROBES[r].typed, PROBES[r].px);

        // Random samples under each register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    bl = RST_BLACK_LEVEL; lg = RST_LUMA_GAIN; w75 = 1'b0;
                    cg = RST_CHROMA_GAIN; mn = 1'b0;
                end
                1: begin
                    bl = '1; lg = '1; w75 = 1'b1; cg = '1; mn = 1'b0;
                end
                2: begin
                    bl = '0; lg = '0; w75 = 1'b0; cg = '0; mn = 1'b0;
                end
                3: begin
                    bl = BLACK_W'($urandom_range(2000, 6000));
                    lg = LGAIN_W'($urandom_range(70000, 90000));
                    w75 = 1'b0;
                    cg = CGAIN_W'($urandom_range(3000, 5000));
                    mn = 1'b0;
                end
                4: begin
                    bl = BLACK_W'($urandom_range(0, 8191));
                    lg = LGAIN_W'($urandom_range(60000, 90000));
                    w75 = 1'($urandom);
                    cg = CGAIN_W'($urandom);
                    mn = 1'b1;
                end
                5: begin
                    bl = BLACK_W'($urandom); lg = LGAIN_W'($urandom); w75 = 1'($urandom);
                    cg = CGAIN_W'($urandom); mn = 1'b0;
                end
                6: begin
                    bl = BLACK_W'($urandom_range(0, 4095));
                    lg = LGAIN_W'($urandom_range(65536, 131072));
                    w75 = 1'b1;
                    cg = CGAIN_W'($urandom_range(2048, 8192));
                    mn = 1'b0;
                end
                default: begin
                    bl = '0; lg = '1; w75 = 1'b0; cg = '0; mn = 1'b0;
                end
            endcase
            load_settings(bl, lg, w75, cg, mn);

            case (ph % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 51; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 51; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            // Back the pipeline up into its input while the sender keeps offering
            if (ph == 4)
                hold_reqs <= hold_reqs + 1;

            repeat (ITEMS_PER_PHASE) begin
                case ($urandom_range(0, 7))
                    0:       y_in = '0;
                    1:       y_in = '1;
                    2:       y_in = regs.black_level + SAMPLE_WIDTH'($urandom_range(0, 255));
                    default: y_in = SAMPLE_WIDTH'($urandom);
                endcase
                i_in = random_chroma();
                q_in = random_chroma();
                send_sample(y_in, i_in, q_in, ($urandom_range(0, 15) == 0), 1'b0, '0);
            end
        end

        drain();
        if (errors == 0)
            $display("yiq_to_rgb_converter_tb: done, clean");
        else
            $display("yiq_to_rgb_converter_tb: done, errors");
        $finish;
    end

endmodule
